>>> design/usaq_pkg.sv
// types and constants for the upload slot admission queue
package usaq_pkg;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] host_addr;
		logic [31:0] file_id;
		logic        queue_capable;
		logic [1:0]  transfer_status;
	} req_t;

	typedef struct packed {
		logic       in_pass;
		logic       accepted;
		logic       queue_revoked;
		logic [5:0] queue_position;
		logic [4:0] pass_count;
		logic [5:0] queued_count;
	} rsp_t;

	localparam logic [1:0] REQ_UPLOAD = 2'd0;
	localparam logic [1:0] REQ_TICK   = 2'd1;
	localparam logic [1:0] REQ_STATUS = 2'd2;

	localparam logic [1:0] XS_SENDING = 2'd1;
	localparam logic [1:0] XS_CLOSED  = 2'd2;

	localparam logic [1:0] REG_MAX_UPLOADS = 2'd0;
	localparam logic [1:0] REG_MAX_QUEUE   = 2'd1;
	localparam logic [1:0] REG_HOST_LIMIT  = 2'd2;

	localparam logic [4:0] RST_MAX_UPLOADS = 5'd4;
	localparam logic [5:0] RST_MAX_QUEUE   = 6'd30;
	localparam logic [5:0] RST_HOST_LIMIT  = 6'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REQ_SCAN,
		ST_REQ_DEC,
		ST_STAT_SCAN,
		ST_TICK_AGE,
		ST_PROMO_READ,
		ST_PROMO_LOAD,
		ST_PROMO_SCAN,
		ST_PROMO_DEC
	} state_t;

endpackage

>>> design/usaq_mem.sv
// synchronous single write port memory with registered read
module usaq_mem #(
	parameter int DEPTH = 32,
	parameter int AW = 5,
	parameter int DW = 72
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/upload_slot_admission_queue_core.sv
// top level of the upload slot admission queue
// Usage: drive req and raise start while busy is low; the transaction is taken
// at that edge and busy stays high until the result is out. done pulses for one
// cycle with rsp holding the result; the receiver cannot stall it, and a new
// transaction may be started in the same cycle that done is high.
// req_type selects upload request, tick or status report (code 3 only reports
// the queue position). Registers are written through the APB port; the user
// must write them only while idle, the block itself does not enforce it.
// State lives in two memories (queue and pass list, one entry each of host,
// file, timer and status) with registered read, scanned entry by entry.
// A request or status report is one scan over both lists. A tick takes an
// aging pass of the same length, then one promotion step per queued entry
// with a pass list scan while it has room, then a position scan; the nested
// queue by pass host lookup sets the worst case.
// Reset empties both lists and loads register defaults; memory contents are
// not cleared since only entries below the fill counts are ever read.
module upload_slot_admission_queue_core #(
	parameter int QUEUE_DEPTH = 32,
	parameter int PASS_DEPTH = 16,
	parameter int POLL_TICKS = 60
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  usaq_pkg::req_t   req,
	output logic             busy,
	output logic             done,
	output usaq_pkg::rsp_t   rsp,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int PAW = (PASS_DEPTH > 1) ? $clog2(PASS_DEPTH) : 1;
	localparam int PCW = $clog2(PASS_DEPTH + 1);
	localparam int MAXD = (QUEUE_DEPTH > PASS_DEPTH) ? QUEUE_DEPTH : PASS_DEPTH;
	localparam int CW = $clog2(MAXD + 1);
	localparam int TW = $clog2(POLL_TICKS + 1);
	localparam int EW = 66 + TW;
	localparam logic [TW-1:0] POLL_T = TW'(POLL_TICKS);
	localparam logic [TW-1:0] REPOLL_T = TW'(POLL_TICKS - POLL_TICKS / 4);
	localparam logic [TW-1:0] ONE_T = TW'(1);

	usaq_pkg::state_t state_q, state_d;
	usaq_pkg::req_t   req_q;

	logic [4:0]     mu_q;
	logic [5:0]     mql_q;
	logic [5:0]     shl_q;
	logic [QCW-1:0] qused_q;
	logic [PCW-1:0] pused_q;

	logic [CW-1:0]  a_q;
	logic           v_s1;
	logic [CW-1:0]  i_s1;

	logic           phit_q;
	logic           active_q;
	logic [PAW-1:0] pidx_q;
	logic [1:0]     pst_q;
	logic           qhit_q;
	logic [QAW-1:0] qidx_q;
	logic [TW-1:0]  qtim_q;
	logic [1:0]     qst_q;
	logic [QCW-1:0] files_q;
	logic [QCW-1:0] qw_q;
	logic [PCW-1:0] pw_q;
	logic [QCW-1:0] r_q;
	logic [EW-1:0]  ent_q;
	logic           found_q;

	logic           inp_q;
	logic           acc_q;
	logic           rev_q;
	logic [8:0]     pos_q;
	logic           done_q;

	logic           q_we, p_we;
	logic [QAW-1:0] q_waddr, q_raddr;
	logic [PAW-1:0] p_waddr, p_raddr;
	logic [EW-1:0]  q_wdata, p_wdata, q_rdata, p_rdata;

	logic [8:0]     plim, qlim;
	logic           pass_room, queue_full;
	logic [CW-1:0]  scan_n;
	logic           issue, scan_end;
	logic           q_ok, p_ok, q_match, q_hostm, p_hostm, p_match;
	logic [31:0]    qh, qf, ph, pf;
	logic [TW-1:0]  qt, pt, q_newt, p_newt;
	logic [1:0]     qs, ps;
	logic           q_keep, p_keep;
	logic           cfg_wr;

	// field views of the read data
	assign qh = q_rdata[EW-1 -: 32];
	assign qf = q_rdata[EW-33 -: 32];
	assign qt = q_rdata[TW+1:2];
	assign qs = q_rdata[1:0];
	assign ph = p_rdata[EW-1 -: 32];
	assign pf = p_rdata[EW-33 -: 32];
	assign pt = p_rdata[TW+1:2];
	assign ps = p_rdata[1:0];

	assign plim = (9'(mu_q) > 9'(PASS_DEPTH)) ? 9'(PASS_DEPTH) : 9'(mu_q);
	assign qlim = (9'(mql_q) > 9'(QUEUE_DEPTH)) ? 9'(QUEUE_DEPTH) : 9'(mql_q);
	assign pass_room = 9'(pused_q) < plim;
	assign queue_full = 9'(qused_q) >= qlim;
	assign scan_n = (CW'(qused_q) > CW'(pused_q)) ? CW'(qused_q) : CW'(pused_q);
	assign issue = (state_q == usaq_pkg::ST_PROMO_SCAN) ? (a_q < CW'(pused_q))
		: (a_q < scan_n);
	assign scan_end = !issue && !v_s1;

	assign q_ok = v_s1 && (i_s1 < CW'(qused_q));
	assign p_ok = v_s1 && (i_s1 < CW'(pused_q));
	assign q_hostm = q_ok && (qh == req_q.host_addr);
	assign q_match = q_hostm && (qf == req_q.file_id);
	assign p_hostm = p_ok && (ph == req_q.host_addr);
	assign p_match = p_hostm && (pf == req_q.file_id);

	// tick aging
	assign q_keep = (qt > ONE_T) && (qs != usaq_pkg::XS_CLOSED);
	assign p_keep = (pt > ONE_T) && (ps != usaq_pkg::XS_CLOSED);
	assign q_newt = (qs == usaq_pkg::XS_SENDING) ? POLL_T : (qt - ONE_T);
	assign p_newt = (ps == usaq_pkg::XS_SENDING) ? POLL_T : (pt - ONE_T);

	usaq_mem #(.DEPTH(QUEUE_DEPTH), .AW(QAW), .DW(EW)) u_queue_mem (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	usaq_mem #(.DEPTH(PASS_DEPTH), .AW(PAW), .DW(EW)) u_pass_mem (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= usaq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_we = 1'b0;
		p_we = 1'b0;
		q_waddr = i_s1[QAW-1:0];
		p_waddr = i_s1[PAW-1:0];
		q_wdata = {req_q.host_addr, req_q.file_id, qt, req_q.transfer_status};
		p_wdata = {req_q.host_addr, req_q.file_id, pt, req_q.transfer_status};
		q_raddr = a_q[QAW-1:0];
		p_raddr = a_q[PAW-1:0];
		case (state_q)
			usaq_pkg::ST_IDLE: begin
				if (start) begin
					case (req.req_type)
						usaq_pkg::REQ_UPLOAD: state_d = usaq_pkg::ST_REQ_SCAN;
						usaq_pkg::REQ_TICK:   state_d = usaq_pkg::ST_TICK_AGE;
						default:              state_d = usaq_pkg::ST_STAT_SCAN;
					endcase
				end
			end
			usaq_pkg::ST_REQ_SCAN: begin
				if (scan_end) begin
					state_d = usaq_pkg::ST_REQ_DEC;
				end
			end
			usaq_pkg::ST_REQ_DEC: begin
				state_d = usaq_pkg::ST_IDLE;
				if (phit_q) begin
					p_we = 1'b1;
					p_waddr = pidx_q;
					p_wdata = {req_q.host_addr, req_q.file_id, POLL_T, pst_q};
				end else if (pass_room && !active_q) begin
					p_we = 1'b1;
					p_waddr = pused_q[PAW-1:0];
					p_wdata = {req_q.host_addr, req_q.file_id, POLL_T, 2'b00};
				end else if (req_q.queue_capable && !queue_full) begin
					if (qhit_q) begin
						q_we = !(qtim_q > REPOLL_T);
						q_waddr = qidx_q;
						q_wdata = {req_q.host_addr, req_q.file_id, POLL_T, qst_q};
					end else begin
						q_we = 9'(files_q) < 9'(shl_q);
						q_waddr = qused_q[QAW-1:0];
						q_wdata = {req_q.host_addr, req_q.file_id, POLL_T, 2'b00};
					end
				end
			end
			usaq_pkg::ST_STAT_SCAN: begin
				q_we = q_match && (req_q.req_type == usaq_pkg::REQ_STATUS);
				p_we = p_match && (req_q.req_type == usaq_pkg::REQ_STATUS);
				if (scan_end) begin
					state_d = usaq_pkg::ST_IDLE;
				end
			end
			usaq_pkg::ST_TICK_AGE: begin
				q_we = q_ok && q_keep;
				q_waddr = qw_q[QAW-1:0];
				q_wdata = {qh, qf, q_newt, qs};
				p_we = p_ok && p_keep;
				p_waddr = pw_q[PAW-1:0];
				p_wdata = {ph, pf, p_newt, ps};
				if (scan_end) begin
					state_d = usaq_pkg::ST_PROMO_READ;
				end
			end
			usaq_pkg::ST_PROMO_READ: begin
				q_raddr = r_q[QAW-1:0];
				if (r_q >= qused_q) begin
					state_d = usaq_pkg::ST_STAT_SCAN;
				end else begin
					state_d = usaq_pkg::ST_PROMO_LOAD;
				end
			end
			usaq_pkg::ST_PROMO_LOAD: begin
				if (pass_room) begin
					state_d = usaq_pkg::ST_PROMO_SCAN;
				end else begin
					state_d = usaq_pkg::ST_PROMO_DEC;
				end
			end
			usaq_pkg::ST_PROMO_SCAN: begin
				if (scan_end) begin
					state_d = usaq_pkg::ST_PROMO_DEC;
				end
			end
			usaq_pkg::ST_PROMO_DEC: begin
				state_d = usaq_pkg::ST_PROMO_READ;
				if (!found_q) begin
					p_we = 1'b1;
					p_waddr = pused_q[PAW-1:0];
					p_wdata = {ent_q[EW-1:TW+2], POLL_T, ent_q[1:0]};
				end else begin
					q_we = 1'b1;
					q_waddr = qw_q[QAW-1:0];
					q_wdata = ent_q;
				end
			end
			default: begin
				state_d = usaq_pkg::ST_IDLE;
			end
		endcase
	end

	// list counts and config
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q <= usaq_pkg::RST_MAX_UPLOADS;
			mql_q <= usaq_pkg::RST_MAX_QUEUE;
			shl_q <= usaq_pkg::RST_HOST_LIMIT;
			qused_q <= '0;
			pused_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				case (paddr[3:2])
					usaq_pkg::REG_MAX_UPLOADS: mu_q <= pwdata[4:0];
					usaq_pkg::REG_MAX_QUEUE:   mql_q <= pwdata[5:0];
					usaq_pkg::REG_HOST_LIMIT:  shl_q <= pwdata[5:0];
					default: ;
				endcase
			end
			case (state_q)
				usaq_pkg::ST_REQ_DEC: begin
					done_q <= 1'b1;
					if (!phit_q && pass_room && !active_q) begin
						pused_q <= pused_q + PCW'(1);
					end else if (!phit_q && req_q.queue_capable && !queue_full && !qhit_q
						&& (9'(files_q) < 9'(shl_q))) begin
						qused_q <= qused_q + QCW'(1);
					end
				end
				usaq_pkg::ST_STAT_SCAN: begin
					if (scan_end) begin
						done_q <= 1'b1;
					end
				end
				usaq_pkg::ST_TICK_AGE: begin
					if (scan_end) begin
						qused_q <= qw_q;
						pused_q <= pw_q;
					end
				end
				usaq_pkg::ST_PROMO_READ: begin
					if (r_q >= qused_q) begin
						qused_q <= qw_q;
					end
				end
				usaq_pkg::ST_PROMO_DEC: begin
					if (!found_q) begin
						pused_q <= pused_q + PCW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// scan datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			a_q <= '0;
		end else begin
			case (state_q)
				usaq_pkg::ST_IDLE, usaq_pkg::ST_PROMO_READ, usaq_pkg::ST_PROMO_LOAD: begin
					v_s1 <= 1'b0;
					a_q <= '0;
				end
				usaq_pkg::ST_REQ_SCAN, usaq_pkg::ST_STAT_SCAN, usaq_pkg::ST_TICK_AGE,
				usaq_pkg::ST_PROMO_SCAN: begin
					v_s1 <= issue;
					if (issue) begin
						a_q <= a_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		i_s1 <= a_q;
		case (state_q)
			usaq_pkg::ST_IDLE: begin
				if (start) begin
					req_q <= req;
					phit_q <= 1'b0;
					active_q <= 1'b0;
					qhit_q <= 1'b0;
					files_q <= '0;
					qw_q <= '0;
					pw_q <= '0;
					r_q <= '0;
					inp_q <= 1'b0;
					acc_q <= 1'b0;
					rev_q <= 1'b0;
					pos_q <= '0;
				end
			end
			usaq_pkg::ST_REQ_SCAN: begin
				if (p_hostm) begin
					active_q <= 1'b1;
				end
				if (p_match && !phit_q) begin
					phit_q <= 1'b1;
					pidx_q <= i_s1[PAW-1:0];
					pst_q <= ps;
				end
				if (q_match && !qhit_q) begin
					qhit_q <= 1'b1;
					qidx_q <= i_s1[QAW-1:0];
					qtim_q <= qt;
					qst_q <= qs;
				end else if (q_hostm && !q_match) begin
					files_q <= files_q + QCW'(1);
				end
			end
			usaq_pkg::ST_REQ_DEC: begin
				if (qhit_q) begin
					pos_q <= 9'(qidx_q) + 9'd1;
				end
				if (phit_q || (pass_room && !active_q)) begin
					inp_q <= 1'b1;
					acc_q <= 1'b1;
				end else if (req_q.queue_capable && !queue_full) begin
					if (qhit_q) begin
						if (qtim_q > REPOLL_T) begin
							rev_q <= 1'b1;
						end else begin
							acc_q <= 1'b1;
						end
					end else if (9'(files_q) < 9'(shl_q)) begin
						acc_q <= 1'b1;
						pos_q <= 9'(qused_q) + 9'd1;
					end
				end
			end
			usaq_pkg::ST_STAT_SCAN: begin
				if (q_match && !qhit_q) begin
					qhit_q <= 1'b1;
					pos_q <= 9'(i_s1) + 9'd1;
				end
			end
			usaq_pkg::ST_TICK_AGE: begin
				if (q_ok && q_keep) begin
					qw_q <= qw_q + QCW'(1);
				end
				if (p_ok && p_keep) begin
					pw_q <= pw_q + PCW'(1);
				end
				if (scan_end) begin
					qw_q <= '0;
				end
			end
			usaq_pkg::ST_PROMO_LOAD: begin
				ent_q <= q_rdata;
				found_q <= !pass_room;
			end
			usaq_pkg::ST_PROMO_SCAN: begin
				if (p_ok && (ph == ent_q[EW-1 -: 32])) begin
					found_q <= 1'b1;
				end
			end
			usaq_pkg::ST_PROMO_DEC: begin
				r_q <= r_q + QCW'(1);
				if (found_q) begin
					qw_q <= qw_q + QCW'(1);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		case (paddr[3:2])
			usaq_pkg::REG_MAX_UPLOADS: prdata = 32'(mu_q);
			usaq_pkg::REG_MAX_QUEUE:   prdata = 32'(mql_q);
			usaq_pkg::REG_HOST_LIMIT:  prdata = 32'(shl_q);
			default:                   prdata = 32'd0;
		endcase
	end

	assign pready = 1'b1;
	assign busy = (state_q != usaq_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp.in_pass = inp_q;
	assign rsp.accepted = acc_q;
	assign rsp.queue_revoked = rev_q;
	assign rsp.queue_position = pos_q[5:0];
	assign rsp.pass_count = 5'(pused_q);
	assign rsp.queued_count = 6'(qused_q);

endmodule

>>> sim/upload_slot_admission_queue_core_tb.sv
// testbench for the upload slot admission queue core with a self-checking scoreboard
`timescale 1ns / 100ps

module upload_slot_admission_queue_core_tb;

	localparam int QDEPTH = 32;
	localparam int PDEPTH = 16;
	localparam int POLL = 60;
	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [1:0] REQ_NOP = 2'd3;

	class admission_scoreboard;
		int max_up, max_q, host_lim;
		logic [31:0] qh[QDEPTH], qf[QDEPTH], ph[PDEPTH], pf[PDEPTH];
		int qt[QDEPTH], pt[PDEPTH];
		logic [1:0] qs[QDEPTH], ps[PDEPTH];
		int qn, pn;
		usaq_pkg::rsp_t pending[$];
		int mismatches, checked;

		function void reset_state();
			max_up = int'(usaq_pkg::RST_MAX_UPLOADS);
			max_q = int'(usaq_pkg::RST_MAX_QUEUE);
			host_lim = int'(usaq_pkg::RST_HOST_LIMIT);
			qn = 0;
			pn = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				usaq_pkg::REG_MAX_UPLOADS: max_up = int'(val[4:0]);
				usaq_pkg::REG_MAX_QUEUE: max_q = int'(val[5:0]);
				usaq_pkg::REG_HOST_LIMIT: host_lim = int'(val[5:0]);
				default: ;
			endcase
		endfunction

		function int pass_cap();
			return max_up > PDEPTH ? PDEPTH : max_up;
		endfunction

		function int queue_cap();
			return max_q > QDEPTH ? QDEPTH : max_q;
		endfunction

		function void q_drop(int i);
			for (int j = i; j + 1 < qn; j++) begin
				qh[j] = qh[j+1]; qf[j] = qf[j+1]; qt[j] = qt[j+1]; qs[j] = qs[j+1];
			end
			qn--;
		endfunction

		function void p_drop(int i);
			for (int j = i; j + 1 < pn; j++) begin
				ph[j] = ph[j+1]; pf[j] = pf[j+1]; pt[j] = pt[j+1]; ps[j] = ps[j+1];
			end
			pn--;
		endfunction

		function bit age(ref int t, input logic [1:0] st);
			if (t <= 1)
				return 0;
			if (st == usaq_pkg::XS_CLOSED)
				return 0;
			t = (st == usaq_pkg::XS_SENDING) ? POLL : t - 1;
			return 1;
		endfunction

		function bit passing(logic [31:0] h);
			for (int i = 0; i < pn; i++)
				if (ph[i] == h)
					return 1;
			return 0;
		endfunction

		function void do_tick();
			int i;
			bit moved;
			i = 0;
			while (i < qn) begin
				if (!age(qt[i], qs[i])) q_drop(i);
				else i++;
			end
			i = 0;
			while (i < pn) begin
				if (!age(pt[i], ps[i])) p_drop(i);
				else i++;
			end
			while (pn < pass_cap()) begin
				moved = 0;
				for (int k = 0; k < qn; k++) begin
					if (!passing(qh[k])) begin
						ph[pn] = qh[k]; pf[pn] = qf[k]; pt[pn] = POLL; ps[pn] = qs[k];
						pn++;
						q_drop(k);
						moved = 1;
						break;
					end
				end
				if (!moved)
					break;
			end
		endfunction

		function bit admit(logic [31:0] h, logic [31:0] f, bit cap, output bit revoked);
			int files;
			bit active;
			files = 0;
			active = 0;
			revoked = 0;
			for (int i = 0; i < pn; i++)
				if (ph[i] == h) begin
					active = 1;
					if (pf[i] == f) begin
						pt[i] = POLL;
						return 1;
					end
				end
			if (pn < pass_cap() && !active) begin
				ph[pn] = h; pf[pn] = f; pt[pn] = POLL; ps[pn] = 2'd0;
				pn++;
				return 1;
			end
			if (!cap || qn >= queue_cap())
				return 0;
			for (int i = 0; i < qn; i++)
				if (qh[i] == h) begin
					if (qf[i] == f) begin
						if (POLL - qt[i] < POLL / 4) begin
							revoked = 1;
							return 0;
						end
						qt[i] = POLL;
						return 1;
					end
					files++;
				end
			if (files < host_lim) begin
				qh[qn] = h; qf[qn] = f; qt[qn] = POLL; qs[qn] = 2'd0;
				qn++;
				return 1;
			end
			return 0;
		endfunction

		function void note_request(usaq_pkg::req_t r);
			usaq_pkg::rsp_t e;
			bit rv;
			e = '0;
			if (r.req_type == usaq_pkg::REQ_UPLOAD) begin
				e.accepted = admit(r.host_addr, r.file_id, r.queue_capable, rv);
				e.queue_revoked = rv;
				if (e.accepted)
					for (int i = 0; i < pn; i++)
						if (ph[i] == r.host_addr && pf[i] == r.file_id)
							e.in_pass = 1;
			end else if (r.req_type == usaq_pkg::REQ_TICK) begin
				do_tick();
			end else if (r.req_type == usaq_pkg::REQ_STATUS) begin
				for (int i = 0; i < qn; i++)
					if (qh[i] == r.host_addr && qf[i] == r.file_id)
						qs[i] = r.transfer_status;
				for (int i = 0; i < pn; i++)
					if (ph[i] == r.host_addr && pf[i] == r.file_id)
						ps[i] = r.transfer_status;
			end
			for (int i = 0; i < qn; i++)
				if (qh[i] == r.host_addr && qf[i] == r.file_id) begin
					e.queue_position = 6'(i + 1);
					break;
				end
			e.pass_count = 5'(pn);
			e.queued_count = 6'(qn);
			pending = {pending, e};
		endfunction

		function void check_result(usaq_pkg::rsp_t a);
			usaq_pkg::rsp_t e;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", a);
				return;
			end
			e = pending.pop_front();
			if (a.in_pass !== e.in_pass || a.accepted !== e.accepted ||
					a.queue_revoked !== e.queue_revoked ||
					a.queue_position !== e.queue_position ||
					a.pass_count !== e.pass_count || a.queued_count !== e.queued_count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch on result %0d: expected %p actual %p", checked, e, a);
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done;
	usaq_pkg::req_t req;
	usaq_pkg::rsp_t rsp;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	admission_scoreboard sb;
	int cycles, idle_pct, sent;
	logic [31:0] hosts[6];
	logic [31:0] files[4];

	upload_slot_admission_queue_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy), .done(done),
		.rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("upload_slot_admission_queue_core_tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done)
			sb.check_result(rsp);

	task automatic send(usaq_pkg::req_t r);
		@(negedge clk);
		req = r;
		start = 1;
		do @(posedge clk); while (busy);
		sb.note_request(r);
		sent++;
	endtask

	task automatic maybe_gap();
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 0;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start = 0;
		while (sb.pending.size() != 0 || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	function automatic usaq_pkg::req_t mk(logic [1:0] t, logic [31:0] h, logic [31:0] f,
			bit c, logic [1:0] s);
		usaq_pkg::req_t r;
		r.req_type = t; r.host_addr = h; r.file_id = f;
		r.queue_capable = c; r.transfer_status = s;
		return r;
	endfunction

	function automatic usaq_pkg::req_t rand_req();
		int k;
		logic [1:0] t;
		logic [31:0] h, f;
		k = $urandom_range(99);
		t = k < 45 ? usaq_pkg::REQ_UPLOAD : k < 78 ? usaq_pkg::REQ_TICK
			: k < 95 ? usaq_pkg::REQ_STATUS : REQ_NOP;
		h = ($urandom_range(19) == 0) ? $urandom : hosts[$urandom_range(5)];
		f = ($urandom_range(19) == 0) ? $urandom : files[$urandom_range(3)];
		return mk(t, h, f, $urandom_range(9) != 0, 2'($urandom_range(3)));
	endfunction

	initial begin
		int cfg[5][3];
		sb = new();
		sb.reset_state();
		cycles = 0; sent = 0; idle_pct = 0;
		arst_n = 0; start = 0; req = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		for (int i = 0; i < 6; i++) hosts[i] = $urandom;
		for (int i = 0; i < 4; i++) files[i] = $urandom;
		cfg = '{'{1, 4, 2}, '{0, 0, 0}, '{31, 63, 63}, '{16, 32, 1}, '{3, 8, 3}};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed part under reset defaults
		send(mk(usaq_pkg::REQ_UPLOAD, 32'h0, 32'h0, 1'b1, 2'd0));
		send(mk(usaq_pkg::REQ_UPLOAD, 32'h0, 32'h0, 1'b1, 2'd0));
		send(mk(usaq_pkg::REQ_UPLOAD, 32'h0, 32'hffffffff, 1'b1, 2'd0));
		send(mk(usaq_pkg::REQ_UPLOAD, 32'h0, 32'hffffffff, 1'b1, 2'd0));
		send(mk(usaq_pkg::REQ_UPLOAD, 32'h0, 32'h5, 1'b0, 2'd0));
		send(mk(usaq_pkg::REQ_UPLOAD, 32'hffffffff, 32'hffffffff, 1'b1, 2'd3));
		send(mk(usaq_pkg::REQ_UPLOAD, 32'h1, 32'h1, 1'b0, 2'd0));
		send(mk(usaq_pkg::REQ_UPLOAD, 32'h2, 32'h2, 1'b1, 2'd0));
		send(mk(usaq_pkg::REQ_UPLOAD, 32'h3, 32'h3, 1'b1, 2'd0));
		send(mk(usaq_pkg::REQ_UPLOAD, 32'h3, 32'h4, 1'b1, 2'd0));
		send(mk(usaq_pkg::REQ_STATUS, 32'h1, 32'h1, 1'b0, usaq_pkg::XS_SENDING));
		send(mk(usaq_pkg::REQ_STATUS, 32'h0, 32'h0, 1'b1, usaq_pkg::XS_CLOSED));
		send(mk(usaq_pkg::REQ_STATUS, 32'h3, 32'h4, 1'b0, 2'd3));
		send(mk(usaq_pkg::REQ_TICK, 32'h0, 32'hffffffff, 1'b0, 2'd0));
		send(mk(REQ_NOP, 32'h3, 32'h4, 1'b1, 2'd3));
		for (int i = 0; i < 16; i++)
			send(mk(usaq_pkg::REQ_TICK, 32'h3, 32'h4, 1'b0, 2'd0));
		send(mk(usaq_pkg::REQ_UPLOAD, 32'h3, 32'h4, 1'b1, 2'd0));
		for (int i = 0; i < 62; i++)
			send(mk(usaq_pkg::REQ_TICK, 32'h1, 32'h1, 1'b0, 2'd0));

		for (int ph = 0; ph < 5; ph++) begin
			drain();
			write_reg(usaq_pkg::REG_MAX_UPLOADS, cfg[ph][0]);
			write_reg(usaq_pkg::REG_MAX_QUEUE, cfg[ph][1]);
			write_reg(usaq_pkg::REG_HOST_LIMIT, cfg[ph][2]);
			idle_pct = ph < 2 ? 17 : ph < 4 ? 65 : 0;
			for (int n = 0; n < 72; n++) begin
				maybe_gap();
				send(rand_req());
			end
		end
		drain();
		repeat (50) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.mismatches += sb.pending.size();
		$display("sent %0d transactions over five register settings, %0d results checked",
			sent, sb.checked);
		$display("mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0)
			$display("upload_slot_admission_queue_core_tb OK");
		else
			$display("upload_slot_admission_queue_core_tb NOT OK");
		$finish;
	end

endmodule
